// ----- src/modexp_pkg.sv -----
// Shared constants and types for the modular exponentiation block.
`default_nettype none

package modexp_pkg;

    // Default operand width of base, exponent, modulus and residue
    localparam int unsigned OPERAND_WIDTH_DEF = 31;

    // Sequencer states
    typedef enum logic [2:0] {
        ST_IDLE,
        ST_REDUCE,
        ST_SETUP,
        ST_MULT,
        ST_DONE
    } state_t;

endpackage : modexp_pkg

`default_nettype wire

// ----- src/modular_exponentiation.sv -----
// Bit-serial right-to-left binary modular exponentiation, top level.
// Sequence: a zero exponent or zero modulus skips straight to the result; otherwise the
//   base is first reduced below the modulus, then one multiply-and-square pass runs for
//   each exponent bit up to the highest set one.
// Throughput: one item at a time; the single shift-and-add modular multiply pair sets the
//   pace at one multiplier bit per cycle. A new item is taken while a result waits.
// Reset: rst_n clears the sequencer, bit counter and output valid asynchronously.
`default_nettype none

module modular_exponentiation #(
    parameter int unsigned OPERAND_WIDTH = modexp_pkg::OPERAND_WIDTH_DEF
) (
    input  wire logic                     clk,
    input  wire logic                     rst_n,
    input  wire logic                     in_valid,
    output logic                          in_ready,
    input  wire logic [OPERAND_WIDTH-1:0] base_value,
    input  wire logic [OPERAND_WIDTH-1:0] power,
    input  wire logic [OPERAND_WIDTH-1:0] divisor,
    output logic                          out_valid,
    input  wire logic                     out_ready,
    output logic [OPERAND_WIDTH-1:0]      residue
);

    localparam int unsigned W  = OPERAND_WIDTH;
    localparam int unsigned CW = $clog2(W);
    localparam logic [CW-1:0] CNT_LAST = CW'(W - 1);

    // ------------------------------------------------------------------
    // Control state
    // ------------------------------------------------------------------
    modexp_pkg::state_t state_reg, state_next;
    logic [CW-1:0]      cnt_reg, cnt_next;
    logic               out_valid_reg, out_valid_next;

    // ------------------------------------------------------------------
    // Datapath registers
    //   mod_reg  : modulus for every reduction
    //   exp_reg  : exponent, shifted right one bit per square step
    //   base_reg : running base (remainder during the initial reduction)
    //   bsh_reg  : multiplier bits of the base (dividend bits while reducing)
    //   acc_reg  : running result
    //   add*_reg : doubling addends of the two multiplies (acc * base, base * base)
    //   prod*_reg: partial products of the two multiplies
    // ------------------------------------------------------------------
    logic [W-1:0] mod_reg,   mod_next;
    logic [W-1:0] exp_reg,   exp_next;
    logic [W-1:0] base_reg,  base_next;
    logic [W-1:0] bsh_reg,   bsh_next;
    logic [W-1:0] acc_reg,   acc_next;
    logic [W-1:0] add1_reg,  add1_next;
    logic [W-1:0] add2_reg,  add2_next;
    logic [W-1:0] prod1_reg, prod1_next;
    logic [W-1:0] prod2_reg, prod2_next;
    logic [W-1:0] residue_reg, residue_next;

    // ------------------------------------------------------------------
    // Narrow arithmetic: every operand stays below the modulus, so each sum or
    // doubling is below twice the modulus and needs one compare and subtract.
    // ------------------------------------------------------------------
    logic [W:0] mod_ext;
    logic [W:0] rem_sh,  rem_red;
    logic [W:0] sum1,    sum1_red;
    logic [W:0] sum2,    sum2_red;
    logic [W:0] dbl1,    dbl1_red;
    logic [W:0] dbl2,    dbl2_red;

    assign mod_ext = {1'b0, mod_reg};

    // Restoring division step for the initial base reduction
    assign rem_sh  = {base_reg, bsh_reg[W-1]};
    assign rem_red = (rem_sh >= mod_ext) ? (rem_sh - mod_ext) : rem_sh;

    assign sum1     = {1'b0, prod1_reg} + {1'b0, add1_reg};
    assign sum1_red = (sum1 >= mod_ext) ? (sum1 - mod_ext) : sum1;
    assign sum2     = {1'b0, prod2_reg} + {1'b0, add2_reg};
    assign sum2_red = (sum2 >= mod_ext) ? (sum2 - mod_ext) : sum2;
    assign dbl1     = {add1_reg, 1'b0};
    assign dbl1_red = (dbl1 >= mod_ext) ? (dbl1 - mod_ext) : dbl1;
    assign dbl2     = {add2_reg, 1'b0};
    assign dbl2_red = (dbl2 >= mod_ext) ? (dbl2 - mod_ext) : dbl2;

    // ------------------------------------------------------------------
    // Sequencer: next state and datapath updates
    // ------------------------------------------------------------------
    always_comb
    begin
        state_next     = state_reg;
        cnt_next       = cnt_reg;
        out_valid_next = out_valid_reg && !out_ready;
        mod_next       = mod_reg;
        exp_next       = exp_reg;
        base_next      = base_reg;
        bsh_next       = bsh_reg;
        acc_next       = acc_reg;
        add1_next      = add1_reg;
        add2_next      = add2_reg;
        prod1_next     = prod1_reg;
        prod2_next     = prod2_reg;
        residue_next   = residue_reg;

        unique case (state_reg)
            modexp_pkg::ST_IDLE:
            begin
                if (in_valid)
                begin
                    mod_next  = divisor;
                    exp_next  = power;
                    bsh_next  = base_value;
                    base_next = '0;
                    cnt_next  = '0;
                    // Running result starts at one mod the modulus
                    acc_next  = (divisor == W'(1)) ? '0 : W'(1);
                    priority if (power == '0)
                    begin
                        // Zero exponent answers one, unreduced
                        acc_next   = W'(1);
                        state_next = modexp_pkg::ST_DONE;
                    end
                    else if (divisor == '0)
                    begin
                        acc_next   = '0;
                        state_next = modexp_pkg::ST_DONE;
                    end
                    else
                    begin
                        state_next = modexp_pkg::ST_REDUCE;
                    end
                end
            end

            modexp_pkg::ST_REDUCE:
            begin
                // Bring one dividend bit into the remainder per cycle
                base_next = rem_red[W-1:0];
                bsh_next  = {bsh_reg[W-2:0], 1'b0};
                cnt_next  = cnt_reg + CW'(1);
                if (cnt_reg == CNT_LAST)
                begin
                    cnt_next   = '0;
                    state_next = modexp_pkg::ST_SETUP;
                end
            end

            modexp_pkg::ST_SETUP:
            begin
                if (exp_reg == '0)
                begin
                    state_next = modexp_pkg::ST_DONE;
                end
                else
                begin
                    add1_next  = acc_reg;
                    add2_next  = base_reg;
                    bsh_next   = base_reg;
                    prod1_next = '0;
                    prod2_next = '0;
                    cnt_next   = '0;
                    state_next = modexp_pkg::ST_MULT;
                end
            end

            modexp_pkg::ST_MULT:
            begin
                // Both multiplies consume the same base bit, LSB first
                if (bsh_reg[0])
                begin
                    prod1_next = sum1_red[W-1:0];
                    prod2_next = sum2_red[W-1:0];
                end
                add1_next = dbl1_red[W-1:0];
                add2_next = dbl2_red[W-1:0];
                bsh_next  = {1'b0, bsh_reg[W-1:1]};
                cnt_next  = cnt_reg + CW'(1);
                if (cnt_reg == CNT_LAST)
                begin
                    // Commit: multiply on a set exponent bit, square always
                    if (exp_reg[0])
                    begin
                        acc_next = bsh_reg[0] ? sum1_red[W-1:0] : prod1_reg;
                    end
                    base_next  = bsh_reg[0] ? sum2_red[W-1:0] : prod2_reg;
                    exp_next   = {1'b0, exp_reg[W-1:1]};
                    cnt_next   = '0;
                    state_next = modexp_pkg::ST_SETUP;
                end
            end

            modexp_pkg::ST_DONE:
            begin
                // Hold until the output register is free
                if (!out_valid_reg || out_ready)
                begin
                    residue_next   = acc_reg;
                    out_valid_next = 1'b1;
                    state_next     = modexp_pkg::ST_IDLE;
                end
            end

            default:
            begin
                state_next = modexp_pkg::ST_IDLE;
            end
        endcase
    end

    // Control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= modexp_pkg::ST_IDLE;
            cnt_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            cnt_reg       <= cnt_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        mod_reg     <= mod_next;
        exp_reg     <= exp_next;
        base_reg    <= base_next;
        bsh_reg     <= bsh_next;
        acc_reg     <= acc_next;
        add1_reg    <= add1_next;
        add2_reg    <= add2_next;
        prod1_reg   <= prod1_next;
        prod2_reg   <= prod2_next;
        residue_reg <= residue_next;
    end

    assign in_ready  = (state_reg == modexp_pkg::ST_IDLE);
    assign out_valid = out_valid_reg;
    assign residue   = residue_reg;

    // ------------------------------------------------------------------
    // Assertions
    // ------------------------------------------------------------------
    a_zero_exp_shortcut: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && in_ready && (power == '0)) |=> (state_reg == modexp_pkg::ST_DONE))
        else $error("zero exponent did not skip to the result");

    a_result_from_done: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid) |-> ($past(state_reg) == modexp_pkg::ST_DONE))
        else $error("result appeared without a finished computation");

    a_mult_operands_reduced: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == modexp_pkg::ST_MULT) |->
            ((prod1_reg < mod_reg) && (prod2_reg < mod_reg) &&
             (add1_reg < mod_reg) && (add2_reg < mod_reg)))
        else $error("multiply operand not reduced below the modulus");

    a_setup_base_reduced: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == modexp_pkg::ST_SETUP) |-> ((base_reg < mod_reg) && (acc_reg < mod_reg)))
        else $error("base or running result not reduced");

endmodule : modular_exponentiation

`default_nettype wire
